// ===== sv/digital_clock_with_time_set_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Digital clock assertion macros
// Shared property forms for the clock and time-set checks.
// ----------------------------------------------------------------------------
`ifndef DIGITAL_CLOCK_WITH_TIME_SET_UNIT_ASSERT_SVH
`define DIGITAL_CLOCK_WITH_TIME_SET_UNIT_ASSERT_SVH

// Same-cycle implication, held off while reset is asserted
`define DCTS_ASSERT_NOW(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
		else $error("digital clock check failed");

// Next-cycle implication, held off while reset is asserted
`define DCTS_ASSERT_NEXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
		else $error("digital clock check failed");

`endif

// ===== sv/dclk_ts_pkg.sv =====
// ----------------------------------------------------------------------------
// Digital clock package
// Item types, mode codes, field codes and the time carry helper.
// ----------------------------------------------------------------------------
package dclk_ts_pkg;

	localparam int unsigned ThresholdWidth = 10;
	localparam int unsigned ElapsedWidth   = 10;

	localparam logic [ThresholdWidth-1:0] THRESHOLD_RESET = 10'd840;
	localparam logic [ElapsedWidth-1:0]   ELAPSED_MAX     = 10'd1023;

	localparam logic [5:0] SECONDS_LIMIT = 6'd60;
	localparam logic [6:0] MINUTES_LIMIT = 7'd60;
	localparam logic [5:0] HOURS_LIMIT   = 6'd24;

	localparam logic [4:0] RESET_HOURS   = 5'd16;
	localparam logic [5:0] RESET_MINUTES = 6'd30;
	localparam logic [5:0] RESET_SECONDS = 6'd30;

	typedef enum logic [1:0] {
		MODE_NORMAL = 2'd0,
		MODE_MENU   = 2'd1,
		MODE_SET    = 2'd2
	} mode_t;

	localparam logic [1:0] FIELD_HOURS   = 2'd0;
	localparam logic [1:0] FIELD_MINUTES = 2'd1;
	localparam logic [1:0] FIELD_SECONDS = 2'd2;

	localparam logic [1:0] MENU_SET_TIME = 2'd0;
	localparam logic [1:0] MENU_LAST     = 2'd3;

	typedef struct packed {
		logic [4:0] hours;
		logic [5:0] minutes;
		logic [5:0] seconds;
	} time_t;

	typedef struct packed {
		logic ms_tick;
		logic mode_button;
		logic done_button;
		logic dec_button;
		logic inc_button;
	} sample_t;

	typedef struct packed {
		logic [4:0] shown_hours;
		logic [5:0] shown_minutes;
		logic [5:0] shown_seconds;
		logic [1:0] current_mode;
		logic [1:0] menu_choice;
		logic [1:0] edit_field;
	} result_t;

	// Wrap each unit at its limit and carry seconds into minutes, minutes into hours
	function automatic time_t time_carry(input logic [5:0] h, input logic [6:0] m,
			input logic [6:0] s);
		logic [5:0] hn;
		logic [6:0] mn;
		logic [6:0] sn;
		time_t      t;
		hn = h;
		mn = m;
		sn = s;
		if (sn >= {1'b0, SECONDS_LIMIT}) begin
			sn = '0;
			mn = mn + 7'd1;
		end
		if (mn >= MINUTES_LIMIT) begin
			mn = '0;
			hn = hn + 6'd1;
		end
		if (hn >= HOURS_LIMIT) begin
			hn = '0;
		end
		t.hours   = hn[4:0];
		t.minutes = mn[5:0];
		t.seconds = sn[5:0];
		return t;
	endfunction

endpackage

// ===== sv/digital_clock_with_time_set_unit.sv =====
// ----------------------------------------------------------------------------
// Digital clock with time set
// Hours:minutes:seconds clock driven by millisecond ticks, with a button menu
// and a set-time mode that edits a copy of the time and commits it on done.
// ----------------------------------------------------------------------------
// One sample item is taken per clock cycle and yields one result item in the next
// cycle. All state updates for an item happen in a single pass of logic between
// the state registers and the result register; the only thing that holds off a
// new sample is a result sitting in the result register while result_stall is
// high. The threshold register may be written at any time cfg_valid is high
// (cfg_ready is always high) but should be changed only while no item is in
// flight.
module digital_clock_with_time_set_unit
	import dclk_ts_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,

	input  logic                      sample_valid,
	output logic                      sample_stall,
	input  sample_t                   sample,

	output logic                      result_valid,
	input  logic                      result_stall,
	output result_t                   result,

	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [ThresholdWidth-1:0] cfg_data
);

	logic [ThresholdWidth-1:0] threshold_q;
	logic [ElapsedWidth-1:0]   elapsed_q, elapsed_d;
	time_t                     clock_q, clock_d;
	time_t                     edit_q, edit_d;
	mode_t                     mode_q, mode_d;
	logic [1:0]                menu_q, menu_d;
	logic [1:0]                field_q, field_d;
	logic [2:0]                prev_buttons_q;
	result_t                   result_q, result_d;
	logic                      result_valid_q;

	logic       accept;
	logic       mode_edge, dec_edge, inc_edge;
	logic       sec_due;
	time_t      clock_tick;
	logic [1:0] field_set;
	time_t      edit_dec;
	time_t      edit_inc;

	assign cfg_ready    = 1'b1;
	assign sample_stall = result_valid_q & result_stall;
	assign accept       = sample_valid & ~sample_stall;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	// bit0 mode, bit1 dec, bit2 inc; an edge is low now after high before
	assign mode_edge = ~sample.mode_button & prev_buttons_q[0];
	assign dec_edge  = ~sample.dec_button  & prev_buttons_q[1];
	assign inc_edge  = ~sample.inc_button  & prev_buttons_q[2];

	assign clock_tick = time_carry({1'b0, clock_q.hours}, {1'b0, clock_q.minutes},
		{1'b0, clock_q.seconds} + 7'd1);

	// Set mode edits: field first, then dec, then inc on the new field
	always_comb begin
		if (mode_edge) begin
			field_set = (field_q < FIELD_SECONDS) ? field_q + 2'd1 : FIELD_HOURS;
		end else begin
			field_set = field_q;
		end

		edit_dec = edit_q;
		if (dec_edge) begin
			priority if (field_set == FIELD_HOURS && edit_q.hours != '0) begin
				edit_dec.hours = edit_q.hours - 5'd1;
			end else if (field_set == FIELD_MINUTES && edit_q.minutes != '0) begin
				edit_dec.minutes = edit_q.minutes - 6'd1;
			end else if (field_set == FIELD_SECONDS && edit_q.seconds != '0) begin
				edit_dec.seconds = edit_q.seconds - 6'd1;
			end else begin
				edit_dec = edit_q;
			end
		end

		if (inc_edge) begin
			edit_inc = time_carry(
				{1'b0, edit_dec.hours}   + {5'd0, field_set == FIELD_HOURS},
				{1'b0, edit_dec.minutes} + {6'd0, field_set == FIELD_MINUTES},
				{1'b0, edit_dec.seconds} + {6'd0, field_set == FIELD_SECONDS});
		end else begin
			edit_inc = edit_dec;
		end
	end

	always_comb begin
		elapsed_d = elapsed_q;
		clock_d   = clock_q;
		edit_d    = edit_q;
		mode_d    = mode_q;
		menu_d    = menu_q;
		field_d   = field_q;

		if (sample.ms_tick && elapsed_q != ELAPSED_MAX) begin
			elapsed_d = elapsed_q + 10'd1;
		end
		sec_due = elapsed_d > threshold_q;

		unique case (mode_q)
			MODE_MENU: begin
				if (sec_due) begin
					elapsed_d = '0;
					clock_d   = clock_tick;
				end
				if (dec_edge && menu_q != MENU_LAST) begin
					menu_d = menu_q + 2'd1;
				end
				if (inc_edge && menu_d != '0) begin
					menu_d = menu_d - 2'd1;
				end
				if (!sample.done_button) begin
					if (menu_d == MENU_SET_TIME) begin
						mode_d  = MODE_SET;
						edit_d  = clock_d;
						field_d = FIELD_HOURS;
					end else begin
						mode_d = MODE_NORMAL;
					end
				end
			end
			MODE_SET: begin
				// clock frozen; count keeps running
				field_d = field_set;
				edit_d  = edit_inc;
				if (!sample.done_button) begin
					clock_d = edit_inc;
					mode_d  = MODE_NORMAL;
				end
			end
			default: begin
				mode_d = MODE_NORMAL;
				if (sec_due) begin
					elapsed_d = '0;
					clock_d   = clock_tick;
				end
				if (!sample.mode_button) begin
					mode_d = MODE_MENU;
					menu_d = MENU_SET_TIME;
				end
			end
		endcase

		result_d.shown_hours   = (mode_d == MODE_SET) ? edit_d.hours   : clock_d.hours;
		result_d.shown_minutes = (mode_d == MODE_SET) ? edit_d.minutes : clock_d.minutes;
		result_d.shown_seconds = (mode_d == MODE_SET) ? edit_d.seconds : clock_d.seconds;
		result_d.current_mode  = mode_d;
		result_d.menu_choice   = menu_d;
		result_d.edit_field    = field_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= THRESHOLD_RESET;
		end else if (cfg_valid && cfg_ready) begin
			threshold_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			elapsed_q      <= '0;
			clock_q        <= '{hours: RESET_HOURS, minutes: RESET_MINUTES,
				seconds: RESET_SECONDS};
			edit_q         <= '0;
			mode_q         <= MODE_NORMAL;
			menu_q         <= MENU_SET_TIME;
			field_q        <= FIELD_HOURS;
			prev_buttons_q <= 3'b111;
		end else if (accept) begin
			elapsed_q      <= elapsed_d;
			clock_q        <= clock_d;
			edit_q         <= edit_d;
			mode_q         <= mode_d;
			menu_q         <= menu_d;
			field_q        <= field_d;
			prev_buttons_q <= {sample.inc_button, sample.dec_button, sample.mode_button};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (!sample_stall) begin
			result_valid_q <= sample_valid;
		end
	end

	// Hold the result while it is stalled
	always_ff @(posedge clk) begin
		if (accept) begin
			result_q <= result_d;
		end
	end

	`include "digital_clock_with_time_set_unit_assert.svh"

	`DCTS_ASSERT_NEXT(a_clock_frozen_in_set, clk, arst_n, mode_q == MODE_SET,
		mode_q != MODE_SET || clock_q == $past(clock_q))
	`DCTS_ASSERT_NEXT(a_set_entry_loads_clock, clk, arst_n, mode_q == MODE_MENU,
		mode_q != MODE_SET || (edit_q == clock_q && field_q == FIELD_HOURS))
	`DCTS_ASSERT_NEXT(a_menu_entry_clears_choice, clk, arst_n, mode_q != MODE_MENU,
		mode_q != MODE_MENU || menu_q == MENU_SET_TIME)

endmodule

// ===== tb/clock_display_checker.sv =====
// ----------------------------------------------------------------------------
// Digital clock display checker
// Watches the sample, result and threshold channels of the clock unit, keeps
// its own model of the clock, menu and set-time state, and compares every
// result item with the display predicted for the matching sample item.
// ----------------------------------------------------------------------------
module clock_display_checker
	import dclk_ts_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,

	input  logic                      sample_valid,
	input  logic                      sample_stall,
	input  sample_t                   sample,

	input  logic                      result_valid,
	input  logic                      result_stall,
	input  result_t                   result,

	input  logic                      cfg_valid,
	input  logic                      cfg_ready,
	input  logic [ThresholdWidth-1:0] cfg_data,

	output int unsigned               mismatches,
	output int unsigned               pending,
	output int unsigned               checked
);

	logic [ThresholdWidth-1:0] threshold_ms;
	logic [ElapsedWidth-1:0]   elapsed_ms;
	time_t                     clock_time;
	time_t                     edit_time;
	mode_t                     mode;
	logic [1:0]                menu_sel;
	logic [1:0]                field_sel;
	logic [2:0]                last_levels;   // bit0 mode, bit1 dec, bit2 inc
	result_t                   expected_displays[$];
	int unsigned               mismatch_count;
	int unsigned               checked_count;

	// Wrap any unit at its limit; seconds carry into minutes, minutes into hours
	function automatic time_t roll_over(input int unsigned h, input int unsigned m,
			input int unsigned s);
		time_t t;
		if (s >= SECONDS_LIMIT) begin
			s = 0;
			m = m + 1;
		end
		if (m >= MINUTES_LIMIT) begin
			m = 0;
			h = h + 1;
		end
		if (h >= HOURS_LIMIT) begin
			h = 0;
		end
		t.hours   = 5'(h);
		t.minutes = 6'(m);
		t.seconds = 6'(s);
		return t;
	endfunction

	task automatic count_second();
		if (elapsed_ms > threshold_ms) begin
			elapsed_ms = '0;
			clock_time = roll_over(clock_time.hours, clock_time.minutes,
				clock_time.seconds + 1);
		end
	endtask

	task automatic advance_clock(input sample_t s, output result_t shown);
		logic        mode_fall;
		logic        dec_fall;
		logic        inc_fall;
		int unsigned h;
		int unsigned m;
		int unsigned sec;
		mode_fall = !s.mode_button && last_levels[0];
		dec_fall  = !s.dec_button && last_levels[1];
		inc_fall  = !s.inc_button && last_levels[2];

		if (s.ms_tick && elapsed_ms != ELAPSED_MAX)
			elapsed_ms = elapsed_ms + 1'b1;

		case (mode)
			MODE_MENU: begin
				count_second();
				if (dec_fall && menu_sel != MENU_LAST)
					menu_sel = menu_sel + 2'd1;
				if (inc_fall && menu_sel != MENU_SET_TIME)
					menu_sel = menu_sel - 2'd1;
				if (!s.done_button) begin
					if (menu_sel == MENU_SET_TIME) begin
						mode      = MODE_SET;
						edit_time = clock_time;
						field_sel = FIELD_HOURS;
					end else begin
						mode = MODE_NORMAL;
					end
				end
			end
			MODE_SET: begin
				// clock frozen; the count keeps running
				if (mode_fall)
					field_sel = (field_sel == FIELD_HOURS || field_sel == FIELD_MINUTES) ?
						field_sel + 2'd1 : FIELD_HOURS;
				if (dec_fall) begin
					if (field_sel == FIELD_HOURS && edit_time.hours != 0)
						edit_time.hours = edit_time.hours - 5'd1;
					else if (field_sel == FIELD_MINUTES && edit_time.minutes != 0)
						edit_time.minutes = edit_time.minutes - 6'd1;
					else if (field_sel == FIELD_SECONDS && edit_time.seconds != 0)
						edit_time.seconds = edit_time.seconds - 6'd1;
				end
				if (inc_fall) begin
					h   = edit_time.hours;
					m   = edit_time.minutes;
					sec = edit_time.seconds;
					case (field_sel)
						FIELD_HOURS:   h = h + 1;
						FIELD_MINUTES: m = m + 1;
						FIELD_SECONDS: sec = sec + 1;
						default: ;
					endcase
					edit_time = roll_over(h, m, sec);
				end
				if (!s.done_button) begin
					clock_time = edit_time;
					mode       = MODE_NORMAL;
				end
			end
			default: begin
				mode = MODE_NORMAL;
				count_second();
				if (!s.mode_button) begin
					mode     = MODE_MENU;
					menu_sel = MENU_SET_TIME;
				end
			end
		endcase

		last_levels = {s.inc_button, s.dec_button, s.mode_button};

		shown.shown_hours   = (mode == MODE_SET) ? edit_time.hours : clock_time.hours;
		shown.shown_minutes = (mode == MODE_SET) ? edit_time.minutes : clock_time.minutes;
		shown.shown_seconds = (mode == MODE_SET) ? edit_time.seconds : clock_time.seconds;
		shown.current_mode  = mode;
		shown.menu_choice   = menu_sel;
		shown.edit_field    = field_sel;
	endtask

	function automatic int unsigned field_diff(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			return 1;
		end
		return 0;
	endfunction

	always @(posedge clk or negedge arst_n) begin : track
		result_t want;
		if (!arst_n) begin
			threshold_ms   = THRESHOLD_RESET;
			elapsed_ms     = '0;
			clock_time     = '{hours: RESET_HOURS, minutes: RESET_MINUTES,
				seconds: RESET_SECONDS};
			edit_time      = '0;
			mode           = MODE_NORMAL;
			menu_sel       = MENU_SET_TIME;
			field_sel      = FIELD_HOURS;
			last_levels    = '1;
			mismatch_count = 0;
			checked_count  = 0;
			expected_displays.delete();
		end else begin
			if (cfg_valid && cfg_ready)
				threshold_ms = cfg_data;

			// compare before predicting: a sample taken now cannot be answered now
			if (result_valid && !result_stall) begin
				if (expected_displays.size() == 0) begin
					$error("result item arrived with no sample item waiting for it");
					mismatch_count++;
				end else begin
					want = expected_displays.pop_front();
					mismatch_count += field_diff("shown_hours", want.shown_hours,
						result.shown_hours);
					mismatch_count += field_diff("shown_minutes", want.shown_minutes,
						result.shown_minutes);
					mismatch_count += field_diff("shown_seconds", want.shown_seconds,
						result.shown_seconds);
					mismatch_count += field_diff("current_mode", want.current_mode,
						result.current_mode);
					mismatch_count += field_diff("menu_choice", want.menu_choice,
						result.menu_choice);
					mismatch_count += field_diff("edit_field", want.edit_field,
						result.edit_field);
					checked_count++;
				end
			end

			if (sample_valid && !sample_stall) begin
				advance_clock(sample, want);
				expected_displays.push_back(want);
			end
		end
		mismatches <= mismatch_count;
		pending    <= expected_displays.size();
		checked    <= checked_count;
	end

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// Digital clock with time set testbench
// Drives button and millisecond samples into the clock unit through a short
// directed walk of the menu and set-time paths, then phases of random
// sequences under several second thresholds, with random gaps and stalls.
// ----------------------------------------------------------------------------
module testbench;
	import dclk_ts_pkg::*;

	localparam int unsigned QUIET_LIMIT = 2000;

	typedef enum int unsigned {
		BTN_NONE,
		BTN_MODE,
		BTN_DONE,
		BTN_DEC,
		BTN_INC
	} button_t;

	logic                      clk          = 1'b0;
	logic                      arst_n       = 1'b0;
	logic                      sample_valid = 1'b0;
	logic                      sample_stall;
	sample_t                   sample       = '1;
	logic                      result_valid;
	logic                      result_stall = 1'b0;
	result_t                   result;
	logic                      cfg_valid    = 1'b0;
	logic                      cfg_ready;
	logic [ThresholdWidth-1:0] cfg_data     = '0;

	int unsigned               mismatches;
	int unsigned               pending;
	int unsigned               checked;
	int unsigned               items_sent   = 0;
	int unsigned               thresholds_written = 0;
	int unsigned               stall_left   = 0;
	bit                        idling_on    = 1'b1;

	digital_clock_with_time_set_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	clock_display_checker checker_inst (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.mismatches   (mismatches),
		.pending      (pending),
		.checked      (checked)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Stall results in random bursts
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_stall <= 1'b0;
			stall_left   <= 0;
		end else if (stall_left != 0) begin
			stall_left   <= stall_left - 1;
			result_stall <= 1'b1;
		end else if (idling_on && $urandom_range(0, 7) == 0) begin
			stall_left   <= $urandom_range(0, 10);
			result_stall <= 1'b1;
		end else begin
			result_stall <= 1'b0;
		end
	end

	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (sample_valid && !sample_stall) ||
					(result_valid && !result_stall) || (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("watchdog: no item moved for %0d cycles", QUIET_LIMIT);
		$display("testbench NOT OK");
		$finish;
	end

	function automatic logic chance(input int unsigned pct);
		return $urandom_range(0, 99) < pct;
	endfunction

	function automatic sample_t levels(input button_t pressed, input logic tick);
		sample_t s;
		s.ms_tick     = tick;
		s.mode_button = (pressed != BTN_MODE);
		s.done_button = (pressed != BTN_DONE);
		s.dec_button  = (pressed != BTN_DEC);
		s.inc_button  = (pressed != BTN_INC);
		return s;
	endfunction

	task automatic send(input sample_t s);
		if (idling_on && $urandom_range(0, 5) == 0) begin
			sample_valid <= 1'b0;
			sample       <= 5'($urandom);
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		sample_valid <= 1'b1;
		sample       <= s;
		@(posedge clk);
		while (sample_stall) @(posedge clk);
		items_sent++;
	endtask

	// Press and release one button
	task automatic tap(input button_t b, input logic tick);
		send(levels(b, tick));
		send(levels(BTN_NONE, tick));
	endtask

	// Hold the sender until every expected result is back, then let the pipe settle
	task automatic drain();
		sample_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_threshold(input logic [ThresholdWidth-1:0] value);
		drain();
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		thresholds_written++;
	endtask

	// Two done levels reach normal from any mode; then open the menu and pick set time
	task automatic to_set_mode(input logic tick);
		send(levels(BTN_DONE, tick));
		send(levels(BTN_DONE, tick));
		send(levels(BTN_MODE, tick));
		send(levels(BTN_NONE, tick));
		send(levels(BTN_DONE, tick));
	endtask

	task automatic directed_part();
		write_threshold(10'd1);
		send(levels(BTN_NONE, 1'b1));
		send(levels(BTN_NONE, 1'b1));
		send('0);                         // everything low: enter menu
		repeat (4) tap(BTN_DEC, 1'b1);    // selection steps up to the last entry
		send(levels(BTN_DONE, 1'b0));     // leave menu to normal
		send(levels(BTN_MODE, 1'b1));
		tap(BTN_INC, 1'b1);               // selection clamps at zero
		send(levels(BTN_DONE, 1'b1));     // enter set mode
		send(levels(BTN_DONE, 1'b1));     // done still held: commit at once
		send(levels(BTN_MODE, 1'b0));
		send(levels(BTN_DONE, 1'b0));
		tap(BTN_DEC, 1'b1);
		tap(BTN_MODE, 1'b0);
		tap(BTN_INC, 1'b1);
		tap(BTN_MODE, 1'b1);
		tap(BTN_MODE, 1'b0);              // field wraps back to hours
		send('1);
		send(levels(BTN_DONE, 1'b1));
	endtask

	// Dial in 23:59:59 over more than 1024 ticks, so the count saturates, then commit
	task automatic long_set_stay();
		to_set_mode(1'b1);
		tap(BTN_MODE, 1'b1);
		repeat (59) tap(BTN_DEC, 1'b1);
		repeat (59) tap(BTN_INC, 1'b1);
		tap(BTN_MODE, 1'b1);
		repeat (59) tap(BTN_DEC, 1'b1);
		repeat (59) tap(BTN_INC, 1'b1);
		tap(BTN_MODE, 1'b1);
		repeat (23) tap(BTN_DEC, 1'b1);
		repeat (23) tap(BTN_INC, 1'b1);
		repeat (480) send(levels(BTN_NONE, 1'b1));
		send(levels(BTN_DONE, 1'b1));
		repeat (3) send(levels(BTN_NONE, 1'b1));
	endtask

	task automatic edit_time();
		int unsigned n;
		sample_t     s;
		to_set_mode(chance(70));
		n = $urandom_range(1, 24);
		repeat (n) begin
			if (chance(10)) begin
				s             = 5'($urandom);
				s.done_button = 1'b1;
				send(s);
			end else begin
				case ($urandom_range(0, 3))
					0:       tap(BTN_MODE, chance(70));
					1:       tap(BTN_DEC, chance(70));
					default: tap(BTN_INC, chance(70));
				endcase
			end
		end
		// now and then leave set mode open for the next sequence
		if (!chance(10))
			send(levels(BTN_DONE, chance(70)));
	endtask

	task automatic menu_walk();
		int unsigned n;
		send(levels(BTN_DONE, chance(70)));
		send(levels(BTN_DONE, chance(70)));
		send(levels(BTN_MODE, chance(70)));
		n = $urandom_range(0, 6);
		repeat (n) begin
			if (chance(15))
				send({1'(chance(70)), 1'b1, 1'b1, 2'($urandom)});
			else
				tap(chance(50) ? BTN_DEC : BTN_INC, chance(70));
		end
		send(levels(chance(85) ? BTN_DONE : BTN_MODE, chance(70)));
	endtask

	task automatic random_phase(input int unsigned budget);
		int unsigned stop_at;
		int unsigned n;
		stop_at = items_sent + budget;
		while (items_sent < stop_at) begin
			case ($urandom_range(0, 9))
				0, 1: begin
					n = $urandom_range(1, 8);
					repeat (n) send(5'($urandom));
				end
				2, 3: menu_walk();
				4, 5, 6: edit_time();
				7, 8: begin
					n = $urandom_range(5, 40);
					repeat (n) send(levels(BTN_NONE, chance(85)));
				end
				default: begin
					// open the menu and abandon it
					send(levels(BTN_MODE, chance(70)));
					n = $urandom_range(1, 6);
					repeat (n) send(5'($urandom));
				end
			endcase
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		directed_part();

		write_threshold(10'd1000);
		long_set_stay();
		random_phase(50);

		write_threshold(10'd1);
		random_phase(150);

		write_threshold(10'd22);
		random_phase(150);

		write_threshold(10'($urandom_range(31, 1000)));
		random_phase(150);

		idling_on = 1'b0;
		write_threshold(THRESHOLD_RESET);
		random_phase(150);

		drain();
		repeat (8) @(posedge clk);

		$display("covered %0d sample items and %0d checked results under %0d thresholds,",
			items_sent, checked, thresholds_written);
		$display("including menu limits, held done, field edits and a saturated count");
		if (pending != 0)
			$error("%0d expected results never arrived", pending);
		if (mismatches == 0 && pending == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

endmodule
